// ----- design/ptmb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptmb_pkg
// Shared constants, types and helpers for the per-pixel temporal mode
// background estimator.
// ----------------------------------------------------------------------------
package ptmb_pkg;

    localparam int PIXELS      = 256;
    localparam int CHANNELS    = 3;
    localparam int COUNT_BITS  = 16;
    localparam int IN_CHANNELS = 3;
    localparam int LEVELS      = 256;

    localparam int PIX_W     = (PIXELS > 1) ? $clog2(PIXELS) : 1;
    localparam int VAL_W     = 8;
    localparam int HIST_AW   = PIX_W + VAL_W;
    localparam int HIST_D    = PIXELS * LEVELS;
    localparam int OUT_CNT_W = 16;
    localparam int BEST_W    = VAL_W + COUNT_BITS;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef struct packed {
        logic               rd_en;
        logic [PIX_W-1:0]   rd_pix;
        logic               wr_en;
        logic [PIX_W-1:0]   s1_pix;
        logic               clr;
        logic [HIST_AW-1:0] clr_addr;
    } t_chan_ctl;

    function automatic logic [OUT_CNT_W-1:0] clamp_cnt(input logic [COUNT_BITS-1:0] c);
        logic [COUNT_BITS-1:0] hi;
        hi = c >> OUT_CNT_W;
        if (hi != '0) begin
            return '1;
        end
        return OUT_CNT_W'(c);
    endfunction

endpackage

// ----- design/ptmb_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptmb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ptmb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/ptmb_chan.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptmb_chan
// One colour channel: histogram and best-value memories, read-modify-write
// with forwarding of the most recent write.
// ----------------------------------------------------------------------------
module ptmb_chan
    import ptmb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_chan_ctl            i_ctl,
    input  logic [VAL_W-1:0]     i_value,
    output logic [VAL_W-1:0]     o_mode,
    output logic [OUT_CNT_W-1:0] o_mode_count
);

    logic [VAL_W-1:0]      r_val1;
    logic                  r_hf_vld;
    logic [HIST_AW-1:0]    r_hf_addr;
    logic [COUNT_BITS-1:0] r_hf_data;
    logic                  r_bf_vld;
    logic [PIX_W-1:0]      r_bf_addr;
    logic [BEST_W-1:0]     r_bf_data;

    logic [COUNT_BITS-1:0] hist_rdata;
    logic [BEST_W-1:0]     best_rdata;
    logic [HIST_AW-1:0]    s1_addr;
    logic [COUNT_BITS-1:0] cnt_cur;
    logic [COUNT_BITS-1:0] cnt_new;
    logic [BEST_W-1:0]     best_cur;
    logic [BEST_W-1:0]     best_new;
    logic [COUNT_BITS-1:0] best_cnt;

    logic                  hist_we;
    logic [HIST_AW-1:0]    hist_waddr;
    logic [COUNT_BITS-1:0] hist_wdata;
    logic                  best_we;
    logic [PIX_W-1:0]      best_waddr;
    logic [BEST_W-1:0]     best_wdata;

    assign s1_addr  = {i_ctl.s1_pix, r_val1};
    assign cnt_cur  = (r_hf_vld && r_hf_addr == s1_addr) ? r_hf_data : hist_rdata;
    assign cnt_new  = (cnt_cur == COUNT_MAX) ? cnt_cur : cnt_cur + 1'b1;
    assign best_cur = (r_bf_vld && r_bf_addr == i_ctl.s1_pix) ? r_bf_data : best_rdata;
    assign best_cnt = best_cur[COUNT_BITS-1:0];
    assign best_new = (cnt_new >= best_cnt) ? {r_val1, cnt_new} : best_cur;

    assign hist_we    = i_ctl.clr || i_ctl.wr_en;
    assign hist_waddr = i_ctl.clr ? i_ctl.clr_addr : s1_addr;
    assign hist_wdata = i_ctl.clr ? '0 : cnt_new;
    assign best_we    = i_ctl.clr || i_ctl.wr_en;
    assign best_waddr = i_ctl.clr ? i_ctl.clr_addr[PIX_W-1:0] : i_ctl.s1_pix;
    assign best_wdata = i_ctl.clr ? '0 : best_new;

    ptmb_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (HIST_D)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (hist_we),
        .i_waddr (hist_waddr),
        .i_wdata (hist_wdata),
        .i_re    (i_ctl.rd_en),
        .i_raddr ({i_ctl.rd_pix, i_value}),
        .o_rdata (hist_rdata)
    );

    ptmb_ram #(
        .WIDTH (BEST_W),
        .DEPTH (PIXELS)
    ) u_best (
        .i_clk   (i_clk),
        .i_we    (best_we),
        .i_waddr (best_waddr),
        .i_wdata (best_wdata),
        .i_re    (i_ctl.rd_en),
        .i_raddr (i_ctl.rd_pix),
        .o_rdata (best_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hf_vld <= 1'b0;
            r_bf_vld <= 1'b0;
        end else if (i_ctl.clr) begin
            r_hf_vld <= 1'b0;
            r_bf_vld <= 1'b0;
        end else if (i_ctl.wr_en) begin
            r_hf_vld <= 1'b1;
            r_bf_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_val1 <= i_value;
        end
        if (i_ctl.wr_en) begin
            r_hf_addr <= s1_addr;
            r_hf_data <= cnt_new;
            r_bf_addr <= i_ctl.s1_pix;
            r_bf_data <= best_new;
        end
    end

    assign o_mode       = best_new[BEST_W-1:COUNT_BITS];
    assign o_mode_count = clamp_cnt(best_new[COUNT_BITS-1:0]);

endmodule

// ----- design/pixel_temporal_mode_background.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_temporal_mode_background
// Per-pixel, per-channel running mode of a video stream, kept in histogram
// memories and updated by read-modify-write.
// ----------------------------------------------------------------------------
//  Channel | Handshake                  | Payload
//  in      | i_in_valid / o_in_ready    | i_pixel_index, i_chan0..2_value
//  out     | o_out_valid / i_out_ready  | o_pixel_out, o_mode0..2, o_mode_count0..2
//
//  One beat per cycle sustained while the output is not stalled.
//  Stage 1 reads histogram and best memories, stage 2 updates, writes back
//  (last write forwarded) and loads the output register.
//  After reset a clearing pass over all 65536 histogram addresses (histogram
//  depth per channel) runs with o_in_ready low.
//  A stalled output holds its beat; input keeps flowing while stage 2 is free.
// ----------------------------------------------------------------------------
module pixel_temporal_mode_background
    import ptmb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [7:0]           i_pixel_index,
    input  logic [7:0]           i_chan0_value,
    input  logic [7:0]           i_chan1_value,
    input  logic [7:0]           i_chan2_value,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [7:0]           o_pixel_out,
    output logic [7:0]           o_mode0,
    output logic [7:0]           o_mode1,
    output logic [7:0]           o_mode2,
    output logic [15:0]          o_mode_count0,
    output logic [15:0]          o_mode_count1,
    output logic [15:0]          o_mode_count2
);

    logic                 r_clr;
    logic [HIST_AW-1:0]   r_clr_addr;
    logic                 r_s1_vld;
    logic [PIX_W-1:0]     r_s1_pix;
    logic                 r_out_vld;
    logic [7:0]           r_out_pix;
    logic [VAL_W-1:0]     r_mode  [IN_CHANNELS];
    logic [OUT_CNT_W-1:0] r_count [IN_CHANNELS];

    logic                 n_s1_vld;
    logic                 n_out_vld;
    logic                 in_acc;
    logic                 s1_adv;
    logic [PIX_W-1:0]     in_pix;
    t_chan_ctl            ctl;
    logic [VAL_W-1:0]     in_val  [IN_CHANNELS];
    logic [VAL_W-1:0]     w_mode  [IN_CHANNELS];
    logic [OUT_CNT_W-1:0] w_count [IN_CHANNELS];

    assign in_pix    = PIX_W'(i_pixel_index % PIXELS);
    assign s1_adv    = r_s1_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_clr && (!r_s1_vld || s1_adv);
    assign in_acc    = i_in_valid && o_in_ready;

    assign in_val[0] = i_chan0_value;
    assign in_val[1] = i_chan1_value;
    assign in_val[2] = i_chan2_value;

    always_comb begin
        ctl.rd_en    = in_acc;
        ctl.rd_pix   = in_pix;
        ctl.wr_en    = s1_adv;
        ctl.s1_pix   = r_s1_pix;
        ctl.clr      = r_clr;
        ctl.clr_addr = r_clr_addr;
    end

    for (genvar c = 0; c < IN_CHANNELS; c++) begin : g_chan
        if (c < CHANNELS) begin : g_on
            ptmb_chan u_chan (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (ctl),
                .i_value      (in_val[c]),
                .o_mode       (w_mode[c]),
                .o_mode_count (w_count[c])
            );
        end else begin : g_off
            assign w_mode[c]  = '0;
            assign w_count[c] = '0;
        end
    end

    always_comb begin
        n_s1_vld = r_s1_vld;
        if (in_acc) begin
            n_s1_vld = 1'b1;
        end else if (s1_adv) begin
            n_s1_vld = 1'b0;
        end
        n_out_vld = r_out_vld;
        if (s1_adv) begin
            n_out_vld = 1'b1;
        end else if (i_out_ready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= 1'b1;
            r_clr_addr <= '0;
            r_s1_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_s1_vld  <= n_s1_vld;
            r_out_vld <= n_out_vld;
            if (r_clr) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == HIST_AW'(HIST_D - 1)) begin
                    r_clr <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_pix <= in_pix;
        end
        if (s1_adv) begin
            r_out_pix <= 8'(r_s1_pix);
            for (int c = 0; c < IN_CHANNELS; c++) begin
                r_mode[c]  <= w_mode[c];
                r_count[c] <= w_count[c];
            end
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_pixel_out   = r_out_pix;
    assign o_mode0       = r_mode[0];
    assign o_mode1       = r_mode[1];
    assign o_mode2       = r_mode[2];
    assign o_mode_count0 = r_count[0];
    assign o_mode_count1 = r_count[1];
    assign o_mode_count2 = r_count[2];

endmodule

// ----- design/ptmb_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptmb_chk
// Port-level checks for the temporal mode background block.
// ----------------------------------------------------------------------------
module ptmb_chk
    import ptmb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        o_in_ready,
    input  logic [7:0]  i_pixel_index,
    input  logic [7:0]  i_chan0_value,
    input  logic [7:0]  i_chan1_value,
    input  logic [7:0]  i_chan2_value,
    input  logic        o_out_valid,
    input  logic        i_out_ready,
    input  logic [7:0]  o_pixel_out,
    input  logic [7:0]  o_mode0,
    input  logic [7:0]  o_mode1,
    input  logic [7:0]  o_mode2,
    input  logic [15:0] o_mode_count0,
    input  logic [15:0] o_mode_count1,
    input  logic [15:0] o_mode_count2
);

    // clearing pass starts right out of reset
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready)
        else $error("input ready right after reset");

    // every reported mode has been seen at least once
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_mode_count0 != 16'd0 && o_mode_count1 != 16'd0
                         && o_mode_count2 != 16'd0))
        else $error("result beat with zero mode count");

    // input stalled while output is stalled and a beat is still pending
    a_no_ready_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && o_out_valid && !i_out_ready)
        |=> (!o_in_ready || i_out_ready))
        else $error("accepted beat with both stages full");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_pixel_out)
                                           && $stable(o_mode0)))
        else $error("stalled result beat changed");

endmodule

bind pixel_temporal_mode_background ptmb_chk u_ptmb_chk (.*);

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for pixel_temporal_mode_background. A queue of pixel
// samples (directed corners, tie cases and random traffic concentrated on a
// few pixels) feeds a valid/ready driver. Accepted beats go through a local
// histogram model whose expected modes are checked in order against every
// output beat.
// ----------------------------------------------------------------------------
module tb
    import ptmb_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 300000;
    localparam int HOLD_CYCLES    = 400;

    typedef struct packed {
        logic [7:0]      pix;
        logic [2:0][7:0] chan;
    } t_px_sample;

    typedef struct packed {
        logic [7:0]       pix;
        logic [2:0][7:0]  mode;
        logic [2:0][15:0] cnt;
    } t_bg_mode;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_in_valid    = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_pixel_index = '0;
    logic [7:0]  i_chan0_value = '0;
    logic [7:0]  i_chan1_value = '0;
    logic [7:0]  i_chan2_value = '0;
    logic        o_out_valid;
    logic        i_out_ready   = 1'b0;
    logic [7:0]  o_pixel_out;
    logic [7:0]  o_mode0;
    logic [7:0]  o_mode1;
    logic [7:0]  o_mode2;
    logic [15:0] o_mode_count0;
    logic [15:0] o_mode_count1;
    logic [15:0] o_mode_count2;

    // per pixel/channel histograms and running modes
    logic [COUNT_BITS-1:0] hist_cnt [PIXELS*CHANNELS*LEVELS] = '{default: '0};
    logic [7:0]            top_val  [PIXELS*CHANNELS]        = '{default: '0};
    logic [COUNT_BITS-1:0] top_cnt  [PIXELS*CHANNELS]        = '{default: '0};

    t_px_sample  pending_samples[$];
    t_bg_mode    expected_modes[$];

    logic        feed_on     = 1'b0;
    logic        in_beat     = 1'b0;
    logic        hold_done   = 1'b0;
    int unsigned hold_left   = 0;
    int unsigned beats_in    = 0;
    int unsigned beats_out   = 0;
    int unsigned dry_cycles  = 0;
    int unsigned mismatches  = 0;
    logic        quiet;

    pixel_temporal_mode_background dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_pixel_index (i_pixel_index),
        .i_chan0_value (i_chan0_value),
        .i_chan1_value (i_chan1_value),
        .i_chan2_value (i_chan2_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_pixel_out   (o_pixel_out),
        .o_mode0       (o_mode0),
        .o_mode1       (o_mode1),
        .o_mode2       (o_mode2),
        .o_mode_count0 (o_mode_count0),
        .o_mode_count1 (o_mode_count1),
        .o_mode_count2 (o_mode_count2)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // window with no idling on either side
    assign quiet = (beats_in >= 450) && (beats_in < 700);

    function automatic t_bg_mode advance_background(input t_px_sample s);
        t_bg_mode              r;
        int unsigned           pix;
        int unsigned           site;
        int unsigned           slot;
        logic [COUNT_BITS-1:0] n;
        r     = '0;
        pix   = s.pix % PIXELS;
        r.pix = 8'(pix);
        for (int c = 0; c < IN_CHANNELS && c < CHANNELS; c++) begin
            site = pix * CHANNELS + c;
            slot = site * LEVELS + s.chan[c];
            n    = hist_cnt[slot];
            if (n != COUNT_MAX) begin
                n = n + 1'b1;
            end
            hist_cnt[slot] = n;
            // ties go to the value just raised
            if (n >= top_cnt[site]) begin
                top_cnt[site] = n;
                top_val[site] = s.chan[c];
            end
            r.mode[c] = top_val[site];
            r.cnt[c]  = (64'(top_cnt[site]) > 64'hFFFF) ? 16'hFFFF : 16'(top_cnt[site]);
        end
        return r;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    task automatic add_sample(input logic [7:0] pix, input logic [7:0] v0,
                              input logic [7:0] v1, input logic [7:0] v2);
        t_px_sample s;
        s.pix  = pix;
        s.chan = {v2, v1, v0};
        pending_samples.insert(pending_samples.size(), s);
    endtask

    // sender
    always @(negedge i_clk) begin
        t_px_sample nx;
        if (feed_on && (!i_in_valid || in_beat)) begin
            if (pending_samples.size() != 0 && (quiet || $urandom_range(0, 99) >= 16)) begin
                nx = pending_samples.pop_front();
                i_in_valid    <= 1'b1;
                i_pixel_index <= nx.pix;
                i_chan0_value <= nx.chan[0];
                i_chan1_value <= nx.chan[1];
                i_chan2_value <= nx.chan[2];
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver, with one long hold-off
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (!hold_done && beats_out >= 300) begin
            hold_done   <= 1'b1;
            hold_left   <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= quiet || ($urandom_range(0, 99) >= 16);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_px_sample s;
        t_bg_mode   want;
        if (!i_rst_n) begin
            in_beat <= 1'b0;
        end else begin
            in_beat <= i_in_valid && o_in_ready;
            if (i_in_valid && o_in_ready) begin
                s.pix  = i_pixel_index;
                s.chan = {i_chan2_value, i_chan1_value, i_chan0_value};
                want   = advance_background(s);
                expected_modes.insert(expected_modes.size(), want);
                beats_in++;
            end
            if (o_out_valid && i_out_ready) begin
                beats_out++;
                if (expected_modes.size() == 0) begin
                    $error("output beat with no pending sample: pixel %0d", o_pixel_out);
                    mismatches++;
                end else begin
                    want = expected_modes.pop_front();
                    check_field("pixel_out", want.pix, o_pixel_out);
                    check_field("mode0", want.mode[0], o_mode0);
                    check_field("mode1", want.mode[1], o_mode1);
                    check_field("mode2", want.mode[2], o_mode2);
                    check_field("mode_count0", want.cnt[0], o_mode_count0);
                    check_field("mode_count1", want.cnt[1], o_mode_count1);
                    check_field("mode_count2", want.cnt[2], o_mode_count2);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            dry_cycles <= 0;
        end else if (dry_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            dry_cycles <= dry_cycles + 1;
        end
    end

    initial begin
        logic [7:0] pix;
        logic [7:0] v [3];

        // corners
        add_sample(8'd0,   8'h00, 8'h00, 8'h00);
        add_sample(8'd255, 8'hFF, 8'hFF, 8'hFF);
        add_sample(8'd0,   8'hFF, 8'h00, 8'hFF);
        add_sample(8'd255, 8'h00, 8'hFF, 8'h00);
        add_sample(8'd170, 8'hAA, 8'h55, 8'hAA);
        add_sample(8'd85,  8'h55, 8'hAA, 8'h55);
        // ties move the mode to the newest value
        add_sample(8'd1, 8'd10, 8'd20, 8'd30);
        add_sample(8'd1, 8'd11, 8'd21, 8'd31);
        add_sample(8'd1, 8'd10, 8'd20, 8'd30);
        add_sample(8'd1, 8'd11, 8'd21, 8'd31);
        add_sample(8'd1, 8'd12, 8'd21, 8'd30);
        add_sample(8'd1, 8'd12, 8'd22, 8'd32);
        add_sample(8'd1, 8'd12, 8'd22, 8'd32);
        // back-to-back same pixel, mixed channels
        add_sample(8'd0, 8'h00, 8'hFF, 8'h00);
        add_sample(8'd0, 8'h00, 8'hFF, 8'h7F);

        repeat (735) begin
            if ($urandom_range(0, 99) < 75) begin
                pix = 8'($urandom_range(0, 7));
                foreach (v[c]) v[c] = 8'($urandom_range(0, 3) * 85);
            end else begin
                pix = 8'($urandom_range(0, 255));
                foreach (v[c]) v[c] = 8'($urandom_range(0, 255));
            end
            add_sample(pix, v[0], v[1], v[2]);
        end

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        feed_on = 1'b1;

        while (pending_samples.size() != 0 || i_in_valid || expected_modes.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (20) @(negedge i_clk);

        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
design/ptmb_pkg.sv
design/ptmb_ram.sv
design/ptmb_chan.sv
design/pixel_temporal_mode_background.sv
design/ptmb_chk.sv
test/tb.sv
